### hw/rtl/chained_range_remap_min_assert.svh
// assertion macros shared by the range remap checker
`ifndef CHAINED_RANGE_REMAP_MIN_ASSERT_SVH
`define CHAINED_RANGE_REMAP_MIN_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CRRM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range remap check failed");

// next-cycle implication, sampled on clk, off during reset
`define CRRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range remap check failed");

`endif

### hw/rtl/crrm_pkg.sv
// shared constants, codes and types of the chained range remap block
package crrm_pkg;

    localparam int STAGE_COUNT       = 7;
    localparam int ENTRIES_PER_STAGE = 64;
    localparam int TABLE_DEPTH       = STAGE_COUNT * ENTRIES_PER_STAGE;
    localparam int DATA_W            = 32;
    localparam int STAGE_FIELD_W     = 3;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int STAGE_IDX_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int FILL_W      = $clog2(ENTRIES_PER_STAGE + 1);

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_XLATE = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_DROP = 1'b1;

    // one table entry as stored in memory
    typedef struct packed {
        logic [DATA_W-1:0] source;
        logic [DATA_W-1:0] target;
        logic [DATA_W-1:0] span;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // table write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } ram_wr_t;

    // finished item handed to the output stage
    typedef struct packed {
        logic              status;
        logic              translate;
        logic [DATA_W-1:0] location;
    } result_t;

endpackage

### hw/rtl/crrm_ram.sv
// generic single write, single read memory with registered read data
module crrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/crrm_match.sv
// shared range compare and offset unit, one table entry per cycle
module crrm_match (
    input  logic [crrm_pkg::DATA_W-1:0] value,
    input  crrm_pkg::entry_t            entry,
    output logic                        hit,
    output logic [crrm_pkg::DATA_W-1:0] mapped
);

    logic [crrm_pkg::DATA_W-1:0] offset;

    // distance from range start, range does not wrap past the top
    assign offset = value - entry.source;
    assign hit    = (value >= entry.source) && (offset < entry.span);
    assign mapped = entry.target + offset;

endmodule

### hw/rtl/crrm_seq.sv
// sequencer: table loads, stage walk over memory, fill counts
module crrm_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_take,
    input  logic                               kind,
    input  logic [crrm_pkg::STAGE_FIELD_W-1:0] stage,
    input  logic [crrm_pkg::DATA_W-1:0]        entry_source,
    input  logic [crrm_pkg::DATA_W-1:0]        entry_target,
    input  logic [crrm_pkg::DATA_W-1:0]        entry_span,
    input  logic [crrm_pkg::DATA_W-1:0]        seed_value,
    output logic                               busy,
    output crrm_pkg::ram_wr_t                  ram_wr,
    output logic [crrm_pkg::ADDR_W-1:0]        ram_rd_addr,
    output logic [crrm_pkg::DATA_W-1:0]        match_value,
    input  logic                               match_hit,
    input  logic [crrm_pkg::DATA_W-1:0]        match_mapped,
    output logic                               res_valid,
    output crrm_pkg::result_t                  res,
    input  logic                               res_free
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                          state_reg, state_next;
    logic [crrm_pkg::FILL_W-1:0]         fill_reg [crrm_pkg::STAGE_COUNT];
    logic [crrm_pkg::FILL_W-1:0]         fill_next [crrm_pkg::STAGE_COUNT];
    logic [crrm_pkg::STAGE_IDX_W-1:0]    walk_reg, walk_next;
    logic [crrm_pkg::ADDR_W-1:0]         base_reg, base_next;
    logic [crrm_pkg::ADDR_W-1:0]         rd_addr_reg, rd_addr_next;
    logic [crrm_pkg::FILL_W-1:0]         cnt_reg, cnt_next;

    logic                                kind_reg, kind_next;
    logic [crrm_pkg::STAGE_FIELD_W-1:0]  stage_reg, stage_next;
    crrm_pkg::entry_t                    ent_reg, ent_next;
    logic [crrm_pkg::DATA_W-1:0]         value_reg, value_next;
    logic                                status_reg, status_next;

    logic                                stage_ok;
    logic [crrm_pkg::STAGE_IDX_W-1:0]    load_idx;
    logic [crrm_pkg::STAGE_IDX_W-1:0]    fill_idx;
    logic [crrm_pkg::FILL_W-1:0]         fill_sel;
    logic [crrm_pkg::ADDR_W-1:0]         load_base;
    logic                                table_full;
    logic                                advance;
    logic                                last_stage;

    // load target stage and its fill count, one count read at a time
    assign stage_ok   = (32'(stage_reg) < crrm_pkg::STAGE_COUNT);
    assign load_idx   = stage_ok ? crrm_pkg::STAGE_IDX_W'(stage_reg) : '0;
    assign fill_idx   = (state_reg == S_LOAD) ? load_idx : walk_reg;
    assign fill_sel   = fill_reg[fill_idx];
    assign table_full = (fill_sel >= crrm_pkg::FILL_W'(crrm_pkg::ENTRIES_PER_STAGE));
    assign load_base  = crrm_pkg::ADDR_W'(load_idx)
                      * crrm_pkg::ADDR_W'(crrm_pkg::ENTRIES_PER_STAGE);
    assign last_stage = (walk_reg == crrm_pkg::STAGE_IDX_W'(crrm_pkg::STAGE_COUNT - 1));

    assign busy        = (state_reg != S_IDLE);
    assign ram_rd_addr = rd_addr_next;
    assign match_value = value_reg;

    assign res.status    = status_reg;
    assign res.translate = kind_reg;
    assign res.location  = value_reg;

    // next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        walk_next    = walk_reg;
        base_next    = base_reg;
        rd_addr_next = rd_addr_reg;
        cnt_next     = cnt_reg;
        kind_next    = kind_reg;
        stage_next   = stage_reg;
        ent_next     = ent_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        ram_wr.en    = 1'b0;
        ram_wr.addr  = load_base + crrm_pkg::ADDR_W'(fill_sel);
        ram_wr.data  = ent_reg;
        res_valid    = 1'b0;
        advance      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    kind_next       = kind;
                    stage_next      = stage;
                    ent_next.source = entry_source;
                    ent_next.target = entry_target;
                    ent_next.span   = entry_span;
                    status_next     = crrm_pkg::STATUS_OK;
                    if (kind == crrm_pkg::KIND_XLATE)
                    begin
                        value_next = seed_value;
                        walk_next  = '0;
                        base_next  = '0;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                value_next = '0;
                if (!stage_ok || table_full)
                begin
                    status_next = crrm_pkg::STATUS_DROP;
                end
                else
                begin
                    ram_wr.en           = 1'b1;
                    fill_next[fill_idx] = fill_sel + crrm_pkg::FILL_W'(1);
                end
                state_next = S_OUT;
            end
            S_WALK:
            begin
                if (fill_sel != '0)
                begin
                    rd_addr_next = base_reg;
                    cnt_next     = crrm_pkg::FILL_W'(1);
                    state_next   = S_CMP;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_CMP:
            begin
                // entry data for rd_addr_reg is on the memory output now
                if (match_hit)
                begin
                    value_next = match_mapped;
                    advance    = 1'b1;
                end
                else if (cnt_reg < fill_sel)
                begin
                    rd_addr_next = rd_addr_reg + crrm_pkg::ADDR_W'(1);
                    cnt_next     = cnt_reg + crrm_pkg::FILL_W'(1);
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_OUT:
            begin
                res_valid = res_free;
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // move on to the next stage or finish the walk
        if (advance)
        begin
            if (last_stage)
            begin
                state_next = S_OUT;
            end
            else
            begin
                walk_next  = walk_reg + crrm_pkg::STAGE_IDX_W'(1);
                base_next  = base_reg + crrm_pkg::ADDR_W'(crrm_pkg::ENTRIES_PER_STAGE);
                state_next = S_WALK;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            walk_reg    <= '0;
            base_reg    <= '0;
            rd_addr_reg <= '0;
            cnt_reg     <= '0;
            for (int i = 0; i < crrm_pkg::STAGE_COUNT; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            walk_reg    <= walk_next;
            base_reg    <= base_next;
            rd_addr_reg <= rd_addr_next;
            cnt_reg     <= cnt_next;
            fill_reg    <= fill_next;
        end
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        stage_reg  <= stage_next;
        ent_reg    <= ent_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

endmodule

### hw/rtl/chained_range_remap_min.sv
// top level of the chained range remap block with lowest location tracking
//
//  channel | handshake             | word
//  --------+-----------------------+--------------------------------------------------
//  in      | in_valid / in_stall   | kind, stage, entry_source, entry_target,
//          |                       | entry_span, seed_value
//  out     | out_valid / out_stall | status, location, lowest_location,
//          |                       | lowest_seed, lowest_valid
//
//  a load word goes from acceptance through S_LOAD and S_OUT into the output register
//  a translate word walks every stage in order, scanning each stage's loaded entries
//  until one hits or all are seen; the single memory read port and the shared compare
//  unit look at one table entry per cycle
//  in_stall stays high from acceptance until the result moves into the output register
//  a result waits in the output register while out_stall is high; the next word is
//  taken meanwhile, and its finished result holds the block busy until the register frees
//  reset clears fill counts and the lowest location, table memory is not cleared
module chained_range_remap_min (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic [crrm_pkg::STAGE_FIELD_W-1:0] stage,
    input  logic [crrm_pkg::DATA_W-1:0]        entry_source,
    input  logic [crrm_pkg::DATA_W-1:0]        entry_target,
    input  logic [crrm_pkg::DATA_W-1:0]        entry_span,
    input  logic [crrm_pkg::DATA_W-1:0]        seed_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               status,
    output logic [crrm_pkg::DATA_W-1:0]        location,
    output logic [crrm_pkg::DATA_W-1:0]        lowest_location,
    output logic [crrm_pkg::DATA_W-1:0]        lowest_seed,
    output logic                               lowest_valid
);

    logic                               busy;
    logic                               in_take;
    crrm_pkg::ram_wr_t                  ram_wr;
    logic [crrm_pkg::ADDR_W-1:0]        ram_rd_addr;
    logic [crrm_pkg::ENTRY_W-1:0]       ram_rd_data;
    crrm_pkg::entry_t                   rd_entry;
    logic [crrm_pkg::DATA_W-1:0]        match_value;
    logic                               match_hit;
    logic [crrm_pkg::DATA_W-1:0]        match_mapped;
    logic                               res_valid;
    crrm_pkg::result_t                  res;
    logic                               res_free;
    logic                               best_upd;

    logic                               out_valid_reg, out_valid_next;
    logic                               status_reg;
    logic [crrm_pkg::DATA_W-1:0]        location_reg;
    logic [crrm_pkg::DATA_W-1:0]        best_loc_reg, best_loc_next;
    logic [crrm_pkg::DATA_W-1:0]        best_seed_reg, best_seed_next;
    logic                               best_valid_reg, best_valid_next;
    logic [crrm_pkg::DATA_W-1:0]        seed_hold_reg;

    assign in_stall = busy;
    assign in_take  = in_valid && !busy;
    assign rd_entry = ram_rd_data;

    // range table memory, all stages back to back
    crrm_ram #(
        .WIDTH (crrm_pkg::ENTRY_W),
        .DEPTH (crrm_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // shared compare and offset unit
    crrm_match u_match (
        .value  (match_value),
        .entry  (rd_entry),
        .hit    (match_hit),
        .mapped (match_mapped)
    );

    // sequencer
    crrm_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_take      (in_take),
        .kind         (kind),
        .stage        (stage),
        .entry_source (entry_source),
        .entry_target (entry_target),
        .entry_span   (entry_span),
        .seed_value   (seed_value),
        .busy         (busy),
        .ram_wr       (ram_wr),
        .ram_rd_addr  (ram_rd_addr),
        .match_value  (match_value),
        .match_hit    (match_hit),
        .match_mapped (match_mapped),
        .res_valid    (res_valid),
        .res          (res),
        .res_free     (res_free)
    );

    // seed of the item in flight, for the lowest location record
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            seed_hold_reg <= seed_value;
        end
    end

    // output register and lowest location update
    assign res_free = !out_valid_reg || !out_stall;
    assign best_upd = res_valid && res.translate
                   && (!best_valid_reg || (res.location < best_loc_reg));

    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        best_loc_next   = best_loc_reg;
        best_seed_next  = best_seed_reg;
        best_valid_next = best_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        if (best_upd)
        begin
            best_loc_next   = res.location;
            best_seed_next  = seed_hold_reg;
            best_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            best_loc_reg   <= '0;
            best_seed_reg  <= '0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            best_loc_reg   <= best_loc_next;
            best_seed_reg  <= best_seed_next;
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            status_reg   <= res.status;
            location_reg <= res.location;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign location        = location_reg;
    assign lowest_location = best_loc_reg;
    assign lowest_seed     = best_seed_reg;
    assign lowest_valid    = best_valid_reg;

endmodule

### hw/rtl/crrm_checker.sv
// port level checks of the chained range remap block, bound to the top level
`include "chained_range_remap_min_assert.svh"

module crrm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        status,
    input logic [crrm_pkg::DATA_W-1:0] location,
    input logic [crrm_pkg::DATA_W-1:0] lowest_location,
    input logic                        lowest_valid
);

    // held result word does not move while stalled
    `CRRM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(location))

    // an accepted word keeps the block busy in the next cycle
    `CRRM_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

    // a dropped entry reports no location
    `CRRM_ASSERT_NOW(a_drop_no_loc, out_valid && status, location == '0)

    // once set, the lowest record stays valid
    `CRRM_ASSERT_NEXT(a_lowest_sticky, lowest_valid, lowest_valid)

    // the lowest location only goes down
    `CRRM_ASSERT_NEXT(a_lowest_monotone, lowest_valid,
                      lowest_location <= $past(lowest_location))

endmodule

bind chained_range_remap_min crrm_checker u_crrm_checker (.*);

### tb/chained_range_remap_min_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the chained range remap block with lowest location tracking
module chained_range_remap_min_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 600;
    localparam int RANDOM_WORDS   = 450;

    // stage index past the last table, always dropped
    localparam logic [crrm_pkg::STAGE_FIELD_W-1:0] STAGE_NONE = '1;

    // one input word as queued for the driver
    typedef struct {
        logic                               kind;
        logic [crrm_pkg::STAGE_FIELD_W-1:0] stage;
        logic [crrm_pkg::DATA_W-1:0]        source;
        logic [crrm_pkg::DATA_W-1:0]        target;
        logic [crrm_pkg::DATA_W-1:0]        span;
        logic [crrm_pkg::DATA_W-1:0]        seed;
        bit                                 drain_first;
    } remap_word_t;

    // one expected output word
    typedef struct {
        logic                        status;
        logic [crrm_pkg::DATA_W-1:0] location;
        logic [crrm_pkg::DATA_W-1:0] lowest_location;
        logic [crrm_pkg::DATA_W-1:0] lowest_seed;
        logic                        lowest_valid;
    } remap_due_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic                               kind = crrm_pkg::KIND_LOAD;
    logic [crrm_pkg::STAGE_FIELD_W-1:0] stage = '0;
    logic [crrm_pkg::DATA_W-1:0]        entry_source = '0;
    logic [crrm_pkg::DATA_W-1:0]        entry_target = '0;
    logic [crrm_pkg::DATA_W-1:0]        entry_span = '0;
    logic [crrm_pkg::DATA_W-1:0]        seed_value = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               status;
    logic [crrm_pkg::DATA_W-1:0]        location;
    logic [crrm_pkg::DATA_W-1:0]        lowest_location;
    logic [crrm_pkg::DATA_W-1:0]        lowest_seed;
    logic                               lowest_valid;

    // predictor copy of the stage tables and the running minimum
    logic [crrm_pkg::DATA_W-1:0] map_source [crrm_pkg::STAGE_COUNT][crrm_pkg::ENTRIES_PER_STAGE];
    logic [crrm_pkg::DATA_W-1:0] map_target [crrm_pkg::STAGE_COUNT][crrm_pkg::ENTRIES_PER_STAGE];
    logic [crrm_pkg::DATA_W-1:0] map_span   [crrm_pkg::STAGE_COUNT][crrm_pkg::ENTRIES_PER_STAGE];
    int unsigned                 map_fill   [crrm_pkg::STAGE_COUNT] = '{default: 0};
    logic [crrm_pkg::DATA_W-1:0] best_loc = '0;
    logic [crrm_pkg::DATA_W-1:0] best_seed = '0;
    logic                        best_ok = 1'b0;

    remap_word_t words_to_send[$];
    remap_due_t  due_results[$];
    remap_word_t cur_word;

    int mismatches = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int send_tick = 0;
    int recv_stall = 0;
    int recv_tick = 0;

    chained_range_remap_min u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .stage           (stage),
        .entry_source    (entry_source),
        .entry_target    (entry_target),
        .entry_span      (entry_span),
        .seed_value      (seed_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .location        (location),
        .lowest_location (lowest_location),
        .lowest_seed     (lowest_seed),
        .lowest_valid    (lowest_valid)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one word to the tables or send a seed through the chain
    function automatic remap_due_t chain_remap(remap_word_t w);
        remap_due_t                  r;
        logic [crrm_pkg::DATA_W-1:0] v;
        logic [crrm_pkg::DATA_W-1:0] offs;
        bit                          hit;
        r.status   = crrm_pkg::STATUS_OK;
        r.location = '0;
        if (w.kind == crrm_pkg::KIND_LOAD)
        begin
            if (w.stage >= crrm_pkg::STAGE_COUNT
                || map_fill[w.stage] >= crrm_pkg::ENTRIES_PER_STAGE)
                r.status = crrm_pkg::STATUS_DROP;
            else
            begin
                map_source[w.stage][map_fill[w.stage]] = w.source;
                map_target[w.stage][map_fill[w.stage]] = w.target;
                map_span[w.stage][map_fill[w.stage]]   = w.span;
                map_fill[w.stage]++;
            end
        end
        else
        begin
            v = w.seed;
            for (int s = 0; s < crrm_pkg::STAGE_COUNT; s++)
            begin
                hit = 1'b0;
                // first entry in load order wins, ranges never wrap past the top
                for (int e = 0; e < map_fill[s] && !hit; e++)
                begin
                    offs = v - map_source[s][e];
                    if (v >= map_source[s][e] && offs < map_span[s][e])
                    begin
                        v   = map_target[s][e] + offs;
                        hit = 1'b1;
                    end
                end
            end
            r.location = v;
            // only a strictly lower location replaces the minimum
            if (!best_ok || v < best_loc)
            begin
                best_loc  = v;
                best_seed = w.seed;
                best_ok   = 1'b1;
            end
        end
        r.lowest_location = best_loc;
        r.lowest_seed     = best_seed;
        r.lowest_valid    = best_ok;
        return r;
    endfunction

    // idle length: mostly short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // value inside one of sixteen narrow windows so ranges and seeds meet
    function automatic logic [crrm_pkg::DATA_W-1:0] near_region(int unsigned spread);
        logic [crrm_pkg::DATA_W-1:0] v;
        v = {4'($urandom_range(0, 15)), 28'h0};
        return v + $urandom_range(0, spread);
    endfunction

    task automatic push_load(logic [crrm_pkg::STAGE_FIELD_W-1:0] stg,
                             logic [crrm_pkg::DATA_W-1:0] src,
                             logic [crrm_pkg::DATA_W-1:0] tgt,
                             logic [crrm_pkg::DATA_W-1:0] len);
        remap_word_t w;
        w.kind        = crrm_pkg::KIND_LOAD;
        w.stage       = stg;
        w.source      = src;
        w.target      = tgt;
        w.span        = len;
        w.seed        = $urandom();
        w.drain_first = 1'b0;
        words_to_send = {words_to_send, w};
    endtask

    task automatic push_seed(logic [crrm_pkg::DATA_W-1:0] sd, bit drain);
        remap_word_t w;
        w.kind        = crrm_pkg::KIND_XLATE;
        w.stage       = crrm_pkg::STAGE_FIELD_W'($urandom());
        w.source      = $urandom();
        w.target      = $urandom();
        w.span        = $urandom();
        w.seed        = sd;
        w.drain_first = drain;
        words_to_send = {words_to_send, w};
    endtask

    task automatic check_field(string name, logic [crrm_pkg::DATA_W-1:0] want,
                               logic [crrm_pkg::DATA_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // driver: presents queued words, holds each until accepted
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        logic       word_up;
        remap_due_t due;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            kind         <= crrm_pkg::KIND_LOAD;
            stage        <= '0;
            entry_source <= '0;
            entry_target <= '0;
            entry_span   <= '0;
            seed_value   <= '0;
            send_gap = 0;
            send_tick = 0;
        end
        else
        begin
            send_tick++;
            word_up = in_valid;
            if (in_valid && !in_stall)
            begin
                due = chain_remap(cur_word);
                due_results = {due_results, due};
                word_up = 1'b0;
            end
            if (!word_up)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (words_to_send.size() > 0 &&
                         !(words_to_send[0].drain_first && due_results.size() > 0))
                begin
                    cur_word = words_to_send.pop_front();
                    kind         <= cur_word.kind;
                    stage        <= cur_word.stage;
                    entry_source <= cur_word.source;
                    entry_target <= cur_word.target;
                    entry_span   <= cur_word.span;
                    seed_value   <= cur_word.seed;
                    word_up = 1'b1;
                    // calm stretch with back to back words now and then
                    send_gap = ((send_tick % 3000) < 800) ? 0 : pick_gap();
                end
            end
            in_valid <= word_up;
        end
    end

    // monitor: compares each accepted output word with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : check_results
        remap_due_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_stall = 0;
            recv_tick = 0;
        end
        else
        begin
            recv_tick++;
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $error("unexpected result word, location %0h", location);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("status", crrm_pkg::DATA_W'(want.status),
                                crrm_pkg::DATA_W'(status));
                    check_field("location", want.location, location);
                    check_field("lowest_location", want.lowest_location, lowest_location);
                    check_field("lowest_seed", want.lowest_seed, lowest_seed);
                    check_field("lowest_valid", crrm_pkg::DATA_W'(want.lowest_valid),
                                crrm_pkg::DATA_W'(lowest_valid));
                end
            end
            // stall episodes, none starting during a calm stretch
            if (recv_stall > 0)
                recv_stall--;
            else if ((recv_tick % 2600) >= 700 && $urandom_range(0, 3) == 0)
                recv_stall = pick_gap();
            out_stall <= (recv_stall > 0);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("chained_range_remap_min: mismatch");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin : run_test
        remap_word_t                        w;
        logic [crrm_pkg::STAGE_FIELD_W-1:0] hot_stage;
        int                                 roll;

        // first seed with empty tables: minimum must not start from zero
        push_seed('1, 1'b0);
        push_seed(32'h8000_0000, 1'b0);
        // out of range stage is dropped
        push_load(STAGE_NONE, '1, '1, '1);
        // range running past the top covers up to all ones without wrap
        push_load(3'd0, 32'hFFFF_FFF0, 32'h4000_0010, '1);
        push_seed('1, 1'b0);
        push_seed(32'h0000_000E, 1'b0);
        // zero span never matches, next entry does
        push_load(3'd1, '0, '1, '0);
        push_load(3'd1, '0, 32'h2000_0000, 32'd16);
        push_seed(32'd3, 1'b0);
        // target plus offset wraps modulo 2^32
        push_load(3'd2, 32'h2000_0000, 32'hFFFF_FFFE, 32'h100);
        push_seed(32'd3, 1'b0);
        // equal location from a later seed keeps the earlier seed
        push_seed(32'h2000_0003, 1'b0);
        // overlapping ranges: first loaded entry wins
        push_load(3'd3, 32'h100, 32'h5000, 32'h100);
        push_load(3'd3, 32'h180, 32'h6000, 32'h100);
        push_seed(32'h190, 1'b0);
        push_load(3'd4, 32'h4000_0000, '0, 32'h100);
        push_load(3'd5, '0, '0, '0);
        push_seed('1, 1'b0);
        // sender waits for the block to empty before this one
        push_seed(32'h190, 1'b1);
        push_load(3'd6, '1, '1, '1);
        push_seed('1, 1'b0);
        push_seed('0, 1'b0);

        // random words, loads leaning on one stage so its table fills
        hot_stage = crrm_pkg::STAGE_FIELD_W'($urandom_range(0, crrm_pkg::STAGE_COUNT - 1));
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            w.kind = ($urandom_range(0, 99) < 45) ? crrm_pkg::KIND_LOAD : crrm_pkg::KIND_XLATE;
            roll = $urandom_range(0, 99);
            if (roll < 35)
                w.stage = hot_stage;
            else if (roll < 40)
                w.stage = crrm_pkg::STAGE_FIELD_W'($urandom_range(crrm_pkg::STAGE_COUNT,
                              (1 << crrm_pkg::STAGE_FIELD_W) - 1));
            else
                w.stage = crrm_pkg::STAGE_FIELD_W'($urandom_range(0,
                              crrm_pkg::STAGE_COUNT - 1));
            w.source = ($urandom_range(0, 99) < 80) ? near_region(4095) : $urandom();
            w.target = ($urandom_range(0, 99) < 80) ? near_region(4095) : $urandom();
            roll = $urandom_range(0, 99);
            if (roll < 5)
                w.span = '0;
            else if (roll < 65)
                w.span = $urandom_range(1, 4096);
            else if (roll < 75)
            begin
                w.source = '1 - $urandom_range(0, 255);
                w.span   = $urandom_range(256, 65535);
            end
            else
                w.span = $urandom();
            roll = $urandom_range(0, 99);
            if (roll < 50)
                w.seed = near_region(8191);
            else if (roll < 60)
                w.seed = $urandom_range(0, 31);
            else if (roll < 70)
                w.seed = $urandom_range(0, 1) ? '1 : '1 - $urandom_range(0, 255);
            else
                w.seed = $urandom();
            w.drain_first = (i % 150 == 149);
            words_to_send = {words_to_send, w};
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (words_to_send.size() > 0 || in_valid)
            @(posedge clk);
        while (due_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("chained_range_remap_min: match");
        else
            $display("chained_range_remap_min: mismatch");
        $finish;
    end

endmodule
